/* rtl/core/enpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package enpt_pkg;

  // raw counter width in use, taken from the low bits of the raw_count field
  localparam int RAW_WIDTH = 16;
  localparam int RAW_FIELD_W = 16;

  // stream payload layout
  localparam int IN_TDATA_W = 24;
  localparam int IN_TUSER_W = 1;
  localparam int OUT_TDATA_W = 32;
  localparam int ENA_LSB = 0;
  localparam int RAW_LSB = 1;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ABS_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_INV = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_LIM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_DIV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POS_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POS_MAX = 3'd6;

  // action codes carried in tuser
  localparam logic [IN_TUSER_W-1:0] ACT_POLL = 1'b0;
  localparam logic [IN_TUSER_W-1:0] ACT_ENABLE = 1'b1;

  // datapath widths
  localparam int ACC_W = 32;
  localparam int PDIV_W = 16;
  localparam int ZOFF_W = 16;
  localparam int POS_W = 34;     // quotient plus offset, or bound
  localparam int DVD_W = 35;     // signed distance from the lower bound
  localparam int DVS_W = 33;     // divisor / span
  localparam int ALU_W = 51;     // holds the widest product
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W = 6;

  // reset values
  localparam logic [PDIV_W-1:0] PULSE_DIV_RST = 16'd1;
  localparam logic [ACC_W-1:0] POS_MAX_RST = 32'd4096;
  localparam logic [ACC_W-1:0] LAST_POS_RST = 32'h8000_0000;
  localparam logic [ACC_W-1:0] INT32_MAX_V = 32'h7fff_ffff;
  localparam logic [ACC_W-1:0] INT32_MIN_V = 32'h8000_0000;

endpackage

`default_nettype wire

/* rtl/core/encoder_position_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// a poll is taken only in idle and runs load, 35-step divide, zero offset add,
// linear clamp (16-step multiply when it fires) or circular wrap (35-step modulo),
// then report, which waits for a free output slot; the shared 51-bit adder serves
// the divide, the modulo and the multiply; enable commands are handled in idle
// reset (rst_n low, synchronous): registers to defaults, accumulator and last
// raw sample to zero, last position to -2^31, enabled set, no result pending

module encoder_position_tracker (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input channel
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [enpt_pkg::IN_TDATA_W-1:0]     in_tdata,   // enable_value, raw_count[15:0], zero pad
  input  wire  [enpt_pkg::IN_TUSER_W-1:0]     in_tuser,   // action
  // result channel
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [enpt_pkg::OUT_TDATA_W-1:0]    out_tdata,  // report_value
  // configuration write port
  input  wire                                 cfg_we,
  input  wire  [enpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [enpt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import enpt_pkg::*;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a transaction
    S_LOAD,   // set up |accumulator| / divider
    S_DIV,    // restoring divide, one bit per cycle
    S_POS,    // sign fix of quotient, add zero offset
    S_LIM,    // clamp or set up the circular modulo
    S_MUL,    // (bound - offset) * divider, shift-add from the msb
    S_SAT,    // saturate the product into the accumulator
    S_MOD,    // restoring divide for the wrap remainder
    S_WRAP,   // non-negative remainder, back into range
    S_RPT     // compare with last position, emit a result
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic              abs_mode_r;
  logic              dir_inv_r;
  logic              lin_lim_r;
  logic [PDIV_W-1:0] pulse_div_r;
  logic [ZOFF_W-1:0] zero_off_r;
  logic [ACC_W-1:0]  pos_min_r;
  logic [ACC_W-1:0]  pos_max_r;

  // tracking state
  logic [RAW_WIDTH-1:0] last_raw_r, last_raw_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [ACC_W-1:0]     last_pos_r, last_pos_nxt;
  logic                 enabled_r, enabled_nxt;

  // shared datapath registers
  logic [DVD_W-1:0]  sh_r, sh_nxt;        // dividend in, quotient out
  logic [DVS_W-1:0]  rem_r, rem_nxt;      // partial remainder
  logic [DVS_W-1:0]  dv_r, dv_nxt;        // divisor or span
  logic              neg_r, neg_nxt;      // sign of the dividend
  logic [POS_W-1:0]  pos_r, pos_nxt;      // working position
  logic [POS_W-1:0]  mcand_r, mcand_nxt;  // multiplicand
  logic [ALU_W-1:0]  prod_r, prod_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // effective divider, zero acts as one
  logic [PDIV_W-1:0] div_eff;
  assign div_eff = (pulse_div_r == '0) ? PDIV_W'(1) : pulse_div_r;

  // shared adder: trial subtract in divide mode, accumulate in multiply mode
  logic [ALU_W-1:0]   alu_a, alu_b, alu_sum;
  logic               alu_cin;
  logic [DVS_W:0]     trial;
  logic               div_ge;
  logic               mul_bit;
  logic               mul_mode;

  assign trial    = {rem_r, sh_r[DVD_W-1]};
  assign mul_mode = (state_r == S_MUL);
  assign mul_bit  = div_eff[4'(PDIV_W-1) - cnt_r[3:0]];

  always_comb begin
    if (mul_mode) begin
      alu_a   = {prod_r[ALU_W-2:0], 1'b0};
      alu_b   = mul_bit ? {{(ALU_W-POS_W){mcand_r[POS_W-1]}}, mcand_r} : '0;
      alu_cin = 1'b0;
    end else begin
      alu_a   = {{(ALU_W-DVS_W-1){1'b0}}, trial};
      alu_b   = ~{{(ALU_W-DVS_W){1'b0}}, dv_r};
      alu_cin = 1'b1;
    end
  end

  assign alu_sum = alu_a + alu_b + {{(ALU_W-1){1'b0}}, alu_cin};
  // both operands non-negative, so the sign of the difference is the borrow
  assign div_ge  = ~alu_sum[ALU_W-1];

  // sign-extended views of the bounds and offset
  logic [POS_W-1:0] lo_x, hi_x, zoff_x;
  assign lo_x   = {{(POS_W-ACC_W){pos_min_r[ACC_W-1]}}, pos_min_r};
  assign hi_x   = {{(POS_W-ACC_W){pos_max_r[ACC_W-1]}}, pos_max_r};
  assign zoff_x = {{(POS_W-ZOFF_W){zero_off_r[ZOFF_W-1]}}, zero_off_r};

  // poll front end
  logic [RAW_WIDTH-1:0] raw_in, raw_delta;
  logic [ACC_W-1:0]     delta_x;
  assign raw_in    = in_tdata[RAW_LSB +: RAW_WIDTH];
  assign raw_delta = raw_in - last_raw_r;
  assign delta_x   = {{(ACC_W-RAW_WIDTH){raw_delta[RAW_WIDTH-1]}}, raw_delta};

  // helpers used in single states
  logic [ACC_W-1:0] acc_mag, q_mag, q_sgn, upos;
  logic [DVD_W-1:0] lo_gap, lo_gap_mag;
  logic [DVS_W-1:0] span, rem_fix;
  logic             sat_hi, sat_lo;

  assign acc_mag    = acc_r[ACC_W-1] ? (~acc_r + ACC_W'(1)) : acc_r;
  assign q_mag      = sh_r[ACC_W-1:0];
  assign q_sgn      = neg_r ? (~q_mag + ACC_W'(1)) : q_mag;
  assign lo_gap     = {pos_r[POS_W-1], pos_r} - {lo_x[POS_W-1], lo_x};
  assign lo_gap_mag = lo_gap[DVD_W-1] ? (~lo_gap + DVD_W'(1)) : lo_gap;
  assign span     = {pos_max_r[ACC_W-1], pos_max_r} - {pos_min_r[ACC_W-1], pos_min_r}
                    + DVS_W'(1);
  assign rem_fix  = (neg_r && (rem_r != '0)) ? (dv_r - rem_r) : rem_r;
  assign upos     = pos_r[ACC_W-1:0];
  // product out of 32-bit range when bit 31 and the bits above it are not all sign
  assign sat_hi   = ~prod_r[ALU_W-1] && (prod_r[ALU_W-2:ACC_W-1] != '0);
  assign sat_lo   = prod_r[ALU_W-1] && (prod_r[ALU_W-2:ACC_W-1] != '1);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    last_raw_nxt  = last_raw_r;
    acc_nxt       = acc_r;
    last_pos_nxt  = last_pos_r;
    enabled_nxt   = enabled_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    neg_nxt       = neg_r;
    pos_nxt       = pos_r;
    mcand_nxt     = mcand_r;
    prod_nxt      = prod_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == ACT_ENABLE) begin
            enabled_nxt = in_tdata[ENA_LSB];
          end else begin
            last_raw_nxt = raw_in;
            acc_nxt      = dir_inv_r ? (acc_r + delta_x) : (acc_r - delta_x);
            state_nxt    = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        neg_nxt   = acc_r[ACC_W-1];
        sh_nxt    = {{(DVD_W-ACC_W){1'b0}}, acc_mag};
        rem_nxt   = '0;
        dv_nxt    = {{(DVS_W-PDIV_W){1'b0}}, div_eff};
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV, S_MOD: begin
        rem_nxt = div_ge ? alu_sum[DVS_W-1:0] : trial[DVS_W-1:0];
        sh_nxt  = {sh_r[DVD_W-2:0], div_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS-1)) begin
          state_nxt = (state_r == S_DIV) ? S_POS : S_WRAP;
        end
      end
      S_POS: begin
        pos_nxt   = {{(POS_W-ACC_W){q_sgn[ACC_W-1]}}, q_sgn} + zoff_x;
        state_nxt = S_LIM;
      end
      S_LIM: begin
        cnt_nxt  = '0;
        prod_nxt = '0;
        if (lin_lim_r) begin
          if ($signed(pos_r) < $signed(lo_x)) begin
            pos_nxt   = lo_x;
            mcand_nxt = lo_x - zoff_x;
            state_nxt = S_MUL;
          end else if ($signed(pos_r) > $signed(hi_x)) begin
            pos_nxt   = hi_x;
            mcand_nxt = hi_x - zoff_x;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_RPT;
          end
        end else if ($signed(pos_min_r) > $signed(pos_max_r)) begin
          // inverted limits collapse onto the minimum
          pos_nxt   = lo_x;
          state_nxt = S_RPT;
        end else begin
          neg_nxt   = lo_gap[DVD_W-1];
          sh_nxt    = lo_gap_mag;
          rem_nxt   = '0;
          dv_nxt    = span;
          state_nxt = S_MOD;
        end
      end
      S_MUL: begin
        prod_nxt = alu_sum;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PDIV_W-1)) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        if (sat_hi) begin
          acc_nxt = INT32_MAX_V;
        end else if (sat_lo) begin
          acc_nxt = INT32_MIN_V;
        end else begin
          acc_nxt = prod_r[ACC_W-1:0];
        end
        state_nxt = S_RPT;
      end
      S_WRAP: begin
        pos_nxt   = lo_x + {{(POS_W-DVS_W){1'b0}}, rem_fix};
        state_nxt = S_RPT;
      end
      S_RPT: begin
        if (upos == last_pos_r) begin
          state_nxt = S_IDLE;
        end else if (!enabled_r) begin
          last_pos_nxt = upos;
          state_nxt    = S_IDLE;
        end else if (!out_valid_r || out_tready) begin
          // output slot free this cycle
          out_valid_nxt = 1'b1;
          out_data_nxt  = abs_mode_r ? upos : (upos - last_pos_r);
          last_pos_nxt  = upos;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      abs_mode_r  <= 1'b0;
      dir_inv_r   <= 1'b0;
      lin_lim_r   <= 1'b0;
      pulse_div_r <= PULSE_DIV_RST;
      zero_off_r  <= '0;
      pos_min_r   <= '0;
      pos_max_r   <= POS_MAX_RST;
      last_raw_r  <= '0;
      acc_r       <= '0;
      last_pos_r  <= LAST_POS_RST;
      enabled_r   <= 1'b1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_raw_r  <= last_raw_nxt;
      acc_r       <= acc_nxt;
      last_pos_r  <= last_pos_nxt;
      enabled_r   <= enabled_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ABS_MODE:  abs_mode_r  <= cfg_wdata[0];
          REG_DIR_INV:   dir_inv_r   <= cfg_wdata[0];
          REG_LIN_LIM:   lin_lim_r   <= cfg_wdata[0];
          REG_PULSE_DIV: pulse_div_r <= cfg_wdata[PDIV_W-1:0];
          REG_ZERO_OFF:  zero_off_r  <= cfg_wdata[ZOFF_W-1:0];
          REG_POS_MIN:   pos_min_r   <= cfg_wdata[ACC_W-1:0];
          REG_POS_MAX:   pos_max_r   <= cfg_wdata[ACC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    rem_r      <= rem_nxt;
    dv_r       <= dv_nxt;
    neg_r      <= neg_nxt;
    pos_r      <= pos_nxt;
    mcand_r    <= mcand_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* bench/position_report_checker.sv */
`timescale 1ns / 1ps

module position_report_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  input  wire                              in_tready,
  input  wire [enpt_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire [enpt_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  wire                              out_tvalid,
  input  wire                              out_tready,
  input  wire [enpt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire                              cfg_we,
  input  wire [enpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [enpt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                               mismatches,
  output int                               outstanding
);
  import enpt_pkg::*;

  localparam longint I32_HI = 64'sd2147483647;
  localparam longint I32_LO = -64'sd2147483648;

  // register copy
  logic        abs_mode, dir_inv, lin_clamp;
  logic [15:0] pulse_div, zero_off;
  logic [31:0] pos_lo, pos_hi;

  // tracking state
  logic [15:0] prev_raw;
  logic [31:0] pulse_acc, last_seen_pos;
  logic        reporting;

  logic [31:0] reports_due[$];
  int          fail_tally = 0;

  assign mismatches = fail_tally;

  task automatic flag_report(input string msg);
    $display("[%0t] position report: %s", $time, msg);
    fail_tally++;
  endtask

  function automatic logic [31:0] clip_to_32(longint v);
    if (v > I32_HI) return 32'h7fff_ffff;
    if (v < I32_LO) return 32'h8000_0000;
    return 32'(v);
  endfunction

  // one counter sample: accumulate, scale, bound, and queue a report on change
  function automatic void track_poll(logic [15:0] raw);
    logic signed [15:0] step;
    logic [31:0]        upos;
    longint             acc, dv, sh, lo, hi, pos, span, r;
    step = raw - prev_raw;
    prev_raw = raw;
    if (dir_inv) pulse_acc = pulse_acc + {{16{step[15]}}, step};
    else pulse_acc = pulse_acc - {{16{step[15]}}, step};
    acc = $signed(pulse_acc);
    dv = (pulse_div == 16'd0) ? 64'sd1 : longint'(pulse_div);
    sh = $signed(zero_off);
    lo = $signed(pos_lo);
    hi = $signed(pos_hi);
    pos = acc / dv + sh;
    if (lin_clamp) begin
      if (pos < lo) begin
        pos = lo;
        pulse_acc = clip_to_32((lo - sh) * dv);
      end else if (pos > hi) begin
        pos = hi;
        pulse_acc = clip_to_32((hi - sh) * dv);
      end
    end else if (lo > hi) begin
      pos = lo;
    end else begin
      span = hi - lo + 1;
      r = (pos - lo) % span;
      if (r < 0) r = r + span;
      pos = lo + r;
    end
    upos = 32'(pos);
    if (upos != last_seen_pos) begin
      if (reporting) reports_due.push_back(abs_mode ? upos : upos - last_seen_pos);
      last_seen_pos = upos;
    end
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      abs_mode = 1'b0;
      dir_inv = 1'b0;
      lin_clamp = 1'b0;
      pulse_div = PULSE_DIV_RST;
      zero_off = '0;
      pos_lo = '0;
      pos_hi = POS_MAX_RST;
      prev_raw = '0;
      pulse_acc = '0;
      last_seen_pos = LAST_POS_RST;
      reporting = 1'b1;
      reports_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ABS_MODE:  abs_mode = cfg_wdata[0];
          REG_DIR_INV:   dir_inv = cfg_wdata[0];
          REG_LIN_LIM:   lin_clamp = cfg_wdata[0];
          REG_PULSE_DIV: pulse_div = cfg_wdata[15:0];
          REG_ZERO_OFF:  zero_off = cfg_wdata[15:0];
          REG_POS_MIN:   pos_lo = cfg_wdata;
          REG_POS_MAX:   pos_hi = cfg_wdata;
          default: ;
        endcase
      end
      // results first: a report can never belong to the item taken on the same edge
      if (out_tvalid && out_tready) begin
        if (reports_due.size() == 0) begin
          flag_report($sformatf("unexpected value %0d", $signed(out_tdata)));
        end else begin
          want = reports_due.pop_front();
          if (out_tdata !== want)
            flag_report($sformatf("got %0d, want %0d", $signed(out_tdata), $signed(want)));
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == ACT_ENABLE) reporting = in_tdata[ENA_LSB];
        else track_poll(in_tdata[RAW_LSB +: RAW_FIELD_W]);
      end
    end
    outstanding <= reports_due.size();
  end

endmodule

/* bench/tb_encoder_position_tracker.sv */
`timescale 1ns / 1ps

module tb_encoder_position_tracker;
  import enpt_pkg::*;

  localparam int PERIOD = 10;
  localparam int SETTLE = 100;      // covers the slowest poll (circular wrap)
  localparam int HOLD_LEN = 400;    // long receiver hold-off
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 8;
  localparam int PER_PHASE = 63;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic              report_abs;
    logic              dir_inv;
    logic              lin_clamp;
    logic [15:0]       pulse_div;
    logic signed [15:0] zero_off;
    logic signed [31:0] pos_lo;
    logic signed [31:0] pos_hi;
  } tracker_cfg_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // enable_value, raw_count[15:0], zero pad
  logic [IN_TUSER_W-1:0]  in_tuser;    // action
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // report_value
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int fail_total;
  int pending_reports;

  // idling knobs, percent of cycles
  int idle_pct = 0;
  int stall_pct = 0;

  // receiver hold-off request and its completion
  bit hold_req = 1'b0;
  bit hold_done;

  logic [15:0] raw_now;   // last counter sample sent
  int cycle_count = 0;

  always #(PERIOD / 2) clk = ~clk;

  encoder_position_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  position_report_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (fail_total),
    .outstanding (pending_reports)
  );

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("encoder_position_tracker: mismatch");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done = 1'b1;
      end
      out_tready <= ($urandom_range(1, 100) > stall_pct);
    end
  end

  // one input transaction; valid stays high when no gap follows
  task automatic send_item(input logic [IN_TUSER_W-1:0] act, input logic ena,
                           input logic [15:0] raw);
    int gap;
    logic [IN_TDATA_W-1:0] word;
    gap = 0;
    while ($urandom_range(1, 100) <= idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[ENA_LSB] = ena;
    word[RAW_LSB +: RAW_FIELD_W] = raw;
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  // counter sample; the enable bit is don't-care for a poll, so it is random
  task automatic poll(input logic [15:0] raw);
    send_item(ACT_POLL, 1'($urandom_range(0, 1)), raw);
    raw_now = raw;
  endtask

  // enable command, with junk in the unused sample bits
  task automatic set_enable(input logic v);
    send_item(ACT_ENABLE, v, 16'($urandom()));
  endtask

  // stop offering, wait for every expected report, then let the block settle
  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // writes every register, plus the unused index, which must be ignored
  task automatic apply_setting(input tracker_cfg_t s);
    cfg_put(REG_ABS_MODE, {31'd0, s.report_abs});
    cfg_put(REG_DIR_INV, {31'd0, s.dir_inv});
    cfg_put(REG_LIN_LIM, {31'd0, s.lin_clamp});
    cfg_put(REG_PULSE_DIV, {16'd0, s.pulse_div});
    cfg_put(REG_ZERO_OFF, {{16{s.zero_off[15]}}, s.zero_off});
    cfg_put(REG_POS_MIN, s.pos_lo);
    cfg_put(REG_POS_MAX, s.pos_hi);
    cfg_put(REG_UNUSED, $urandom());
    cfg_we <= 1'b0;
  endtask

  function automatic tracker_cfg_t make_setting(logic report_abs, logic dir_inv,
                                                logic lin_clamp, logic [15:0] pulse_div,
                                                logic [15:0] zero_off, logic [31:0] pos_lo,
                                                logic [31:0] pos_hi);
    tracker_cfg_t s;
    s.report_abs = report_abs;
    s.dir_inv = dir_inv;
    s.lin_clamp = lin_clamp;
    s.pulse_div = pulse_div;
    s.zero_off = zero_off;
    s.pos_lo = pos_lo;
    s.pos_hi = pos_hi;
    return s;
  endfunction

  function automatic tracker_cfg_t random_setting();
    tracker_cfg_t s;
    logic signed [31:0] swap;
    int pick;
    s.report_abs = 1'($urandom_range(0, 1));
    s.dir_inv = 1'($urandom_range(0, 1));
    s.lin_clamp = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    case (pick)
      0:       s.pulse_div = 16'd0;         // acts as one
      1:       s.pulse_div = 16'hffff;
      2, 3:    s.pulse_div = 16'($urandom());
      default: s.pulse_div = 16'($urandom_range(1, 8));
    endcase
    pick = $urandom_range(0, 5);
    case (pick)
      0:       s.zero_off = 16'sh0000;
      1:       s.zero_off = 16'sh8000;
      2:       s.zero_off = 16'sh7fff;
      3:       s.zero_off = 16'($urandom());
      default: s.zero_off = 16'($urandom_range(0, 600) - 300);
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        s.pos_lo = 32'sh8000_0000;
        s.pos_hi = 32'sh7fff_ffff;
      end
      1: begin
        s.pos_lo = $urandom();
        s.pos_hi = s.pos_lo;
      end
      2: begin
        // inverted bounds
        s.pos_lo = $urandom_range(0, 2000) - 1000;
        s.pos_hi = s.pos_lo - $urandom_range(1, 500);
      end
      3: begin
        s.pos_lo = $urandom();
        s.pos_hi = $urandom();
        if (s.pos_lo > s.pos_hi) begin
          swap = s.pos_lo;
          s.pos_lo = s.pos_hi;
          s.pos_hi = swap;
        end
      end
      default: begin
        s.pos_lo = -$urandom_range(0, 3000);
        s.pos_hi = s.pos_lo + $urandom_range(1, 6000);
      end
    endcase
    return s;
  endfunction

  initial begin
    tracker_cfg_t cur;
    int ph, k, pick, span;

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= ACT_POLL;
    cfg_we <= 1'b0;
    cfg_index <= REG_ABS_MODE;
    cfg_wdata <= '0;
    raw_now = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first poll lands on -2^31, same as the reset position: nothing reported
    apply_setting(make_setting(1'b1, 1'b0, 1'b1, 16'd1, 16'd0, 32'h8000_0000, 32'h8000_0000));
    poll(16'h0000);
    poll(16'h0003);
    drain(SETTLE);

    // reset-like circular setting, counter wrap in both directions, enable toggling
    apply_setting(make_setting(1'b0, 1'b0, 1'b0, 16'd1, 16'd0, 32'd0, 32'd4096));
    poll(16'h7fff);
    poll(16'h8000);
    poll(16'hffff);
    poll(16'h0000);
    poll(16'h8000);
    set_enable(1'b0);
    poll(16'h1234);    // tracked while disabled, no report
    poll(16'h1234);    // no change
    set_enable(1'b1);
    poll(16'h1200);
    drain(SETTLE);

    // linear clamp at both ends, inverted direction, zero divider, lowest shift
    apply_setting(make_setting(1'b1, 1'b1, 1'b1, 16'd0, 16'h8000, -32'sd100, 32'sd100));
    poll(raw_now + 16'd10);
    poll(raw_now + 16'd32767);
    poll(raw_now - 16'd30000);
    drain(SETTLE);

    // circular with min above max pins the position at min
    apply_setting(make_setting(1'b0, 1'b0, 1'b0, 16'd3, 16'd0, 32'sd10, -32'sd10));
    poll(raw_now + 16'd500);
    poll(raw_now - 16'd2000);
    drain(SETTLE);

    // linear with min above max, largest divider and shift
    apply_setting(make_setting(1'b1, 1'b0, 1'b1, 16'hffff, 16'h7fff, 32'sd50, -32'sd50));
    poll(raw_now + 16'd9000);
    poll(raw_now - 16'd20000);
    drain(SETTLE);

    // full 32-bit span, relative reports wrap
    apply_setting(make_setting(1'b0, 1'b1, 1'b0, 16'd1, 16'h7fff,
                               32'h8000_0000, 32'h7fff_ffff));
    poll(raw_now + 16'd32767);
    poll(raw_now + 16'h8000);
    poll(raw_now + 16'd1);
    drain(SETTLE);

    // random phases: mostly smooth counter motion, some jumps and enable commands
    for (ph = 0; ph < PHASES; ph++) begin
      cur = random_setting();
      apply_setting(cur);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      span = 4 * int'(cur.pulse_div) + 50;
      if (span > 32767) span = 32767;
      for (k = 0; k < PER_PHASE; k++) begin
        // back-pressure: receiver holds while the sender keeps going
        if (ph == 4 && k == 10) hold_req = 1'b1;
        // sender pause until every expected report is out
        if (ph == 5 && k == 30) drain(0);
        pick = $urandom_range(1, 100);
        if (pick <= 8) set_enable($urandom_range(1, 100) <= 70);
        else if (pick <= 14) poll(16'($urandom()));
        else poll(16'(raw_now + $urandom_range(0, 2 * span) - span));
      end
      drain(SETTLE);
    end

    if (fail_total == 0 && pending_reports == 0) begin
      $display("encoder_position_tracker: match");
    end else begin
      $display("encoder_position_tracker: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/enpt_pkg.sv
rtl/core/encoder_position_tracker.sv
bench/position_report_checker.sv
bench/tb_encoder_position_tracker.sv
